/* hdl/sw_pkg.sv */
package sw_pkg;

    localparam int LAP_DEPTH          = 20;
    localparam int TICKS_PER_SECOND   = 100;
    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MAX_MINUTES        = 99;

    localparam int KIND_W    = 3;
    localparam int MIN_W     = 7;
    localparam int SEC_W     = 6;
    localparam int CEN_W     = 7;
    localparam int LAP_IDX_W = 5;
    localparam int LAP_CNT_W = 5;
    localparam int LAP_PTR_W = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_TOGGLE = 3'd1,
        KIND_KEY    = 3'd2,
        KIND_RESET  = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    // decoded request, one flag per action
    typedef struct packed {
        logic tick;
        logic toggle;
        logic key;
        logic space;
        logic reset_req;
        logic confirmed;
        logic read;
    } cmd_t;

    typedef struct packed {
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
        logic [CEN_W-1:0] centis;
    } time_t;

    typedef struct packed {
        time_t                now;
        logic                 running;
        logic [LAP_CNT_W-1:0] lap_count;
        logic                 lap_valid;
        logic [LAP_CNT_W-1:0] lap_number;
        time_t                lap;
        logic                 reset_refused;
    } res_t;

endpackage

/* hdl/sw_timer.sv */
module sw_timer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  sw_pkg::cmd_t  cmd,
    output logic          run_reg,
    output logic          run_next,
    output sw_pkg::time_t time_reg,
    output sw_pkg::time_t time_next,
    output logic          clear
);

    localparam logic [sw_pkg::CEN_W-1:0] CEN_LAST = sw_pkg::CEN_W'(sw_pkg::TICKS_PER_SECOND - 1);
    localparam logic [sw_pkg::SEC_W-1:0] SEC_LAST =
        sw_pkg::SEC_W'(sw_pkg::SECONDS_PER_MINUTE - 1);
    localparam logic [sw_pkg::MIN_W-1:0] MIN_TOP = sw_pkg::MIN_W'(sw_pkg::MAX_MINUTES);

    sw_pkg::time_t adv;

    assign clear = cmd.reset_req && !run_reg && cmd.confirmed;

    // cascade: hundredths, then seconds, minutes hold at the top
    always_comb
    begin
        adv = time_reg;
        if (time_reg.centis >= CEN_LAST)
        begin
            adv.centis = '0;
            if (time_reg.seconds >= SEC_LAST)
            begin
                adv.seconds = '0;
                if (time_reg.minutes < MIN_TOP)
                    adv.minutes = time_reg.minutes + 1'b1;
                else
                    adv.minutes = MIN_TOP;
            end
            else
            begin
                adv.seconds = time_reg.seconds + 1'b1;
            end
        end
        else
        begin
            adv.centis = time_reg.centis + 1'b1;
        end
    end

    always_comb
    begin
        time_next = time_reg;
        run_next  = run_reg;
        if (accept)
        begin
            if (cmd.tick && run_reg)
                time_next = adv;
            if (cmd.toggle)
                run_next = !run_reg;
            if (clear)
                time_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            time_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            time_reg <= time_next;
        end
    end

endmodule

/* hdl/sw_laps.sv */
module sw_laps (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  sw_pkg::cmd_t                 cmd,
    input  logic                         run,
    input  logic                         clear,
    input  sw_pkg::time_t                now,
    input  logic [sw_pkg::LAP_IDX_W-1:0] idx,
    output logic [sw_pkg::LAP_CNT_W-1:0] count_reg,
    output logic [sw_pkg::LAP_CNT_W-1:0] count_next,
    output logic                         rd_valid,
    output logic [sw_pkg::LAP_CNT_W-1:0] rd_number,
    output sw_pkg::time_t                rd_lap
);

    localparam logic [sw_pkg::LAP_CNT_W-1:0] DEPTH = sw_pkg::LAP_CNT_W'(sw_pkg::LAP_DEPTH);

    sw_pkg::time_t                    store_mem [sw_pkg::LAP_DEPTH];
    logic [sw_pkg::LAP_CNT_W-1:0]     base;
    logic                             wr_en;

    // a full store empties on any key press while running
    assign base  = (count_reg >= DEPTH) ? '0 : count_reg;
    assign wr_en = accept && cmd.key && run && cmd.space;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (cmd.key && run)
                count_next = cmd.space ? base + 1'b1 : base;
            if (clear)
                count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[base[sw_pkg::LAP_PTR_W-1:0]] <= now;
    end

    assign rd_valid  = cmd.read && (sw_pkg::LAP_CNT_W'(idx) < count_reg)
                       && (sw_pkg::LAP_CNT_W'(idx) < DEPTH);
    assign rd_number = rd_valid ? sw_pkg::LAP_CNT_W'(idx) + 1'b1 : '0;
    assign rd_lap    = rd_valid ? store_mem[idx[sw_pkg::LAP_PTR_W-1:0]] : '0;

endmodule

/* hdl/sw_outbuf.sv */
module sw_outbuf (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  sw_pkg::res_t in_data,
    output logic         full,
    output logic         out_valid,
    output sw_pkg::res_t out_data,
    input  logic         out_stall
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    sw_pkg::res_t main_reg;
    sw_pkg::res_t skid_reg;
    logic         accept;
    logic         take;
    logic         load_main;
    logic         load_skid;
    logic         move_skid;

    assign full   = skid_valid_reg;
    assign accept = in_valid && !skid_valid_reg;
    assign take   = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        load_skid       = 1'b0;
        move_skid       = 1'b0;
        priority if (skid_valid_reg)
        begin
            if (take)
            begin
                move_skid       = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!main_valid_reg || take)
            begin
                load_main       = 1'b1;
                main_valid_next = 1'b1;
            end
            else
            begin
                // main is held by the stall: park the request
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_skid)
            main_reg <= skid_reg;
        else if (load_main)
            main_reg <= in_data;
        if (load_skid)
            skid_reg <= in_data;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

/* hdl/stopwatch_with_lap_memory.sv */
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  kind, is_space, confirmed, lap_index
// output   out        out_valid/ out_stall minutes .. reset_refused (11 fields)
//
// One request a cycle while in_stall is low; its result is registered into the output buffer on acceptance.
// State (time, run flag, lap count, lap store) updates at the accepting edge.
// A two-entry output buffer (result register plus skid register) sets the rate:
// in_stall rises only once both hold results, after a request is accepted while out_stall holds one.
// rst_n clears time, run flag, lap count and both buffer valids; lap entries are not cleared.
module stopwatch_with_lap_memory (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sw_pkg::KIND_W-1:0]    kind,
    input  logic                         is_space,
    input  logic                         confirmed,
    input  logic [sw_pkg::LAP_IDX_W-1:0] lap_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sw_pkg::MIN_W-1:0]     minutes,
    output logic [sw_pkg::SEC_W-1:0]     seconds,
    output logic [sw_pkg::CEN_W-1:0]     centis,
    output logic                         running,
    output logic [sw_pkg::LAP_CNT_W-1:0] lap_count,
    output logic                         lap_valid,
    output logic [sw_pkg::LAP_CNT_W-1:0] lap_number,
    output logic [sw_pkg::MIN_W-1:0]     lap_minutes,
    output logic [sw_pkg::SEC_W-1:0]     lap_seconds,
    output logic [sw_pkg::CEN_W-1:0]     lap_centis,
    output logic                         reset_refused
);

    sw_pkg::cmd_t                 cmd;
    logic                         accept;
    logic                         buf_full;
    logic                         run_reg;
    logic                         run_next;
    logic                         clear;
    sw_pkg::time_t                time_reg;
    sw_pkg::time_t                time_next;
    logic [sw_pkg::LAP_CNT_W-1:0] count_reg;
    logic [sw_pkg::LAP_CNT_W-1:0] count_next;
    logic                         rd_valid;
    logic [sw_pkg::LAP_CNT_W-1:0] rd_number;
    sw_pkg::time_t                rd_lap;
    sw_pkg::res_t                 res;
    sw_pkg::res_t                 out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    always_comb
    begin
        cmd           = '0;
        cmd.space     = is_space;
        cmd.confirmed = confirmed;
        unique case (sw_pkg::kind_t'(kind))
            sw_pkg::KIND_TICK:   cmd.tick      = 1'b1;
            sw_pkg::KIND_TOGGLE: cmd.toggle    = 1'b1;
            sw_pkg::KIND_KEY:    cmd.key       = 1'b1;
            sw_pkg::KIND_RESET:  cmd.reset_req = 1'b1;
            sw_pkg::KIND_READ:   cmd.read      = 1'b1;
            default:             cmd.tick      = 1'b0;
        endcase
    end

    sw_timer u_timer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .run_reg   (run_reg),
        .run_next  (run_next),
        .time_reg  (time_reg),
        .time_next (time_next),
        .clear     (clear)
    );

    sw_laps u_laps (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .run        (run_reg),
        .clear      (clear),
        .now        (time_reg),
        .idx        (lap_index),
        .count_reg  (count_reg),
        .count_next (count_next),
        .rd_valid   (rd_valid),
        .rd_number  (rd_number),
        .rd_lap     (rd_lap)
    );

    always_comb
    begin
        res               = '0;
        res.now           = time_next;
        res.running       = run_next;
        res.lap_count     = count_next;
        res.lap_valid     = rd_valid;
        res.lap_number    = rd_number;
        res.lap           = rd_lap;
        res.reset_refused = cmd.reset_req && run_reg;
    end

    sw_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_data   (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

    assign minutes       = out_data.now.minutes;
    assign seconds       = out_data.now.seconds;
    assign centis        = out_data.now.centis;
    assign running       = out_data.running;
    assign lap_count     = out_data.lap_count;
    assign lap_valid     = out_data.lap_valid;
    assign lap_number    = out_data.lap_number;
    assign lap_minutes   = out_data.lap.minutes;
    assign lap_seconds   = out_data.lap.seconds;
    assign lap_centis    = out_data.lap.centis;
    assign reset_refused = out_data.reset_refused;

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |-> out_valid)
        else $error("skid register holds a result while the output is empty");

    a_lap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sw_pkg::LAP_CNT_W'(sw_pkg::LAP_DEPTH))
        else $error("lap count beyond store depth");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (time_reg.centis < sw_pkg::CEN_W'(sw_pkg::TICKS_PER_SECOND))
        && (time_reg.seconds < sw_pkg::SEC_W'(sw_pkg::SECONDS_PER_MINUTE))
        && (time_reg.minutes <= sw_pkg::MIN_W'(sw_pkg::MAX_MINUTES)))
        else $error("time counter out of range");

    a_frozen_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (!run_reg && !clear) |=> $stable(time_reg))
        else $error("time changed while stopped");

endmodule
